// ----- hdl/srbps_pkg.sv -----
// Shared widths, defaults and operation codes for the sample ring buffer.
`timescale 1ns / 1ps
package srbps_pkg;

  localparam int DefDepth    = 1024;
  localparam int DefMaxBurst = 64;

  localparam int KindW   = 3;
  localparam int SampleW = 16;
  localparam int CountW  = 10;
  localparam int OffsetW = 10;
  localparam int LenW    = 11;
  localparam int FillW   = 10;
  localparam int LenRst  = 1024;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE = 3'd0,
    KIND_READ  = 3'd1,
    KIND_PEEK  = 3'd2,
    KIND_SKIP  = 3'd3,
    KIND_CLEAR = 3'd4
  } kind_e;

endpackage

// ----- hdl/srbps_in_if.sv -----
// Input channel: operation transactions into the sample ring buffer.
`timescale 1ns / 1ps
interface srbps_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [srbps_pkg::KindW-1:0]          kind;
  logic signed [srbps_pkg::SampleW-1:0] sample;
  logic [srbps_pkg::CountW-1:0]         count;
  logic [srbps_pkg::OffsetW-1:0]        offset;

  modport source (output valid, kind, sample, count, offset, input ready);
  modport sink (input valid, kind, sample, count, offset, output ready);
endinterface

// ----- hdl/srbps_out_if.sv -----
// Output channel: result transactions from the sample ring buffer.
`timescale 1ns / 1ps
interface srbps_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [srbps_pkg::SampleW-1:0] sample_res;
  logic                                 ok;
  logic                                 last;
  logic [srbps_pkg::FillW-1:0]          fill_level;

  modport source (output valid, sample_res, ok, last, fill_level, input ready);
  modport sink (input valid, sample_res, ok, last, fill_level, output ready);
endinterface

// ----- hdl/sample_ring_buffer_peek_skip.sv -----
// Top level: circular sample FIFO with burst write, read, peek, skip and clear.
//
//   channel  dir  handshake     payload
//   in_i     in   valid/ready   kind, sample, count, offset
//   out_o    out  valid/ready   sample_res, ok, last, fill_level
//   cfg      in   cfg_we_i      cfg_wdata_i (buffer_length)
//
// One transaction at a time; in_i.ready is high only while the sequencer is idle.
// Write, skip, clear and refused items each give one result.
// Accepted read/peek of N samples gives N results (read adds a pointer step first);
// one wrap-adder is shared by all pointer advances and the memory read port is registered.
// A stalled out_o holds the sequencer in its emit or result state; no clearing pass after reset.
`timescale 1ns / 1ps
module sample_ring_buffer_peek_skip #(
  parameter int DEPTH     = srbps_pkg::DefDepth,
  parameter int MAX_BURST = srbps_pkg::DefMaxBurst
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srbps_pkg::LenW-1:0]   cfg_wdata_i,
  srbps_in_if.sink                     in_i,
  srbps_out_if.source                  out_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > 11) ? LW + 1 : 12;
  localparam int RW = $clog2(MAX_BURST + 1);
  localparam int LenRstV = (DEPTH < srbps_pkg::LenRst) ? DEPTH : srbps_pkg::LenRst;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RDADV  = 3'd2;
  localparam logic [2:0] S_MEMRD  = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0]                            state_q, state_d;
  logic [srbps_pkg::KindW-1:0]           kind_q;
  logic signed [srbps_pkg::SampleW-1:0]  sample_q;
  logic [srbps_pkg::CountW-1:0]          count_q;
  logic [srbps_pkg::OffsetW-1:0]         offset_q;
  logic [LW-1:0]                         len_q, len_d;
  logic [PW-1:0]                         wp_q, wp_d, rp_q, rp_d, pos_q, pos_d;
  logic                                  refusing_q, refusing_d;
  logic [srbps_pkg::CountW-1:0]          burst_q, burst_d;
  logic [RW-1:0]                         rem_q, rem_d;
  logic                                  ok_q, ok_d;
  logic signed [srbps_pkg::SampleW-1:0]  rd_q;
  logic signed [srbps_pkg::SampleW-1:0]  mem_q [DEPTH];
  logic                                  mem_we, mem_re;

  logic                                  out_valid_q, out_valid_d;
  logic signed [srbps_pkg::SampleW-1:0]  out_sample_q, out_sample_d;
  logic                                  out_ok_q, out_ok_d;
  logic                                  out_last_q, out_last_d;
  logic [srbps_pkg::FillW-1:0]           out_fill_q, out_fill_d;
  logic                                  out_load;

  logic [CW-1:0] len_c, cap_c, wp_c, rp_c, fill_c, count_c, off_c, cfg_c;
  logic [CW-1:0] ub, sum_c, wrap_c;
  logic [PW-1:0] ua, unit_r;
  logic          out_free, store_req, is_rd;

  // Fill level from the pointers
  always_comb begin
    len_c = CW'(len_q);
    cap_c = len_c - CW'(1);
    wp_c  = CW'(wp_q);
    rp_c  = CW'(rp_q);
    if (wp_c < rp_c) begin
      fill_c = wp_c + len_c - rp_c;
    end else begin
      fill_c = wp_c - rp_c;
    end
    count_c  = CW'(count_q);
    is_rd    = (kind_q == srbps_pkg::KIND_READ);
    off_c    = is_rd ? '0 : CW'(offset_q);
    cfg_c    = CW'(cfg_wdata_i);
    out_free = !out_valid_q || out_o.ready;
  end

  // Shared wrap adder
  always_comb begin
    ua = rp_q;
    ub = '0;
    unique case (state_q)
      S_DECIDE: begin
        if (kind_q == srbps_pkg::KIND_WRITE) begin
          ua = wp_q;
          ub = CW'(1);
        end else if (kind_q == srbps_pkg::KIND_SKIP) begin
          ub = count_c;
        end else begin
          ub = off_c;
        end
      end
      S_RDADV: ub = count_c;
      S_MEMRD: begin
        ua = pos_q;
        ub = CW'(1);
      end
      default: ub = '0;
    endcase
    sum_c  = CW'(ua) + ub;
    wrap_c = (sum_c >= len_c) ? sum_c - len_c : sum_c;
    unit_r = wrap_c[PW-1:0];
  end

  always_comb begin
    state_d      = state_q;
    len_d        = len_q;
    wp_d         = wp_q;
    rp_d         = rp_q;
    pos_d        = pos_q;
    refusing_d   = refusing_q;
    burst_d      = burst_q;
    rem_d        = rem_q;
    ok_d         = ok_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    store_req    = 1'b0;
    out_load     = 1'b0;
    out_sample_d = out_sample_q;
    out_ok_d     = out_ok_q;
    out_last_d   = out_last_q;
    out_fill_d   = out_fill_q;
    out_valid_d  = out_valid_q && !out_o.ready;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        ok_d    = 1'b0;
        state_d = S_RESP;
        unique case (kind_q)
          srbps_pkg::KIND_WRITE: begin
            if (burst_q == '0) begin
              if (count_q == '0) begin
                burst_d = '0;
              end else if (count_c <= cap_c - fill_c) begin
                refusing_d = 1'b0;
                burst_d    = count_q - srbps_pkg::CountW'(1);
                store_req  = 1'b1;
              end else begin
                refusing_d = 1'b1;
                burst_d    = count_q - srbps_pkg::CountW'(1);
              end
            end else begin
              burst_d   = burst_q - srbps_pkg::CountW'(1);
              store_req = !refusing_q;
            end
            if (store_req && (fill_c + CW'(1) <= cap_c)) begin
              mem_we = 1'b1;
              wp_d   = unit_r;
              ok_d   = 1'b1;
            end
            if (burst_d == '0) begin
              refusing_d = 1'b0;
            end
          end
          srbps_pkg::KIND_READ, srbps_pkg::KIND_PEEK: begin
            if (count_q != '0 && count_c <= CW'(MAX_BURST) &&
                count_c + off_c <= fill_c) begin
              pos_d   = unit_r;
              rem_d   = count_q[RW-1:0];
              state_d = is_rd ? S_RDADV : S_MEMRD;
            end
          end
          srbps_pkg::KIND_SKIP: begin
            if (count_c <= fill_c) begin
              rp_d = unit_r;
              ok_d = 1'b1;
            end
          end
          srbps_pkg::KIND_CLEAR: begin
            wp_d       = '0;
            rp_d       = '0;
            refusing_d = 1'b0;
            burst_d    = '0;
            ok_d       = 1'b1;
          end
          default: ok_d = 1'b0;
        endcase
      end
      S_RDADV: begin
        rp_d    = unit_r;
        state_d = S_MEMRD;
      end
      S_MEMRD: begin
        mem_re  = 1'b1;
        pos_d   = unit_r;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_sample_d = rd_q;
          out_ok_d     = 1'b1;
          out_last_d   = (rem_q == RW'(1));
          out_fill_d   = fill_c[srbps_pkg::FillW-1:0];
          rem_d        = rem_q - RW'(1);
          state_d      = (rem_q == RW'(1)) ? S_IDLE : S_MEMRD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_sample_d = '0;
          out_ok_d     = ok_q;
          out_last_d   = 1'b1;
          out_fill_d   = fill_c[srbps_pkg::FillW-1:0];
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end

    if (cfg_we_i) begin
      priority if (cfg_c == '0) begin
        len_d = LW'(1);
      end else if (cfg_c > CW'(DEPTH)) begin
        len_d = LW'(DEPTH);
      end else begin
        len_d = cfg_c[LW-1:0];
      end
      wp_d       = '0;
      rp_d       = '0;
      refusing_d = 1'b0;
      burst_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= LW'(LenRstV);
      wp_q        <= '0;
      rp_q        <= '0;
      refusing_q  <= 1'b0;
      burst_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      refusing_q  <= refusing_d;
      burst_q     <= burst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_i.valid) begin
      kind_q   <= in_i.kind;
      sample_q <= in_i.sample;
      count_q  <= in_i.count;
      offset_q <= in_i.offset;
    end
    pos_q        <= pos_d;
    rem_q        <= rem_d;
    ok_q         <= ok_d;
    out_sample_q <= out_sample_d;
    out_ok_q     <= out_ok_d;
    out_last_q   <= out_last_d;
    out_fill_q   <= out_fill_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wp_q] <= sample_q;
    end
    if (mem_re) begin
      rd_q <= mem_q[pos_q];
    end
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_res = out_sample_q;
  assign out_o.ok         = out_ok_q;
  assign out_o.last       = out_last_q;
  assign out_o.fill_level = out_fill_q;

endmodule
